// File: rtl/sem_pkg.sv
// Shared types and constants for the RGB Sobel edge magnitude block.
// Used by every module in rtl/; depends on nothing else.
`timescale 1ns / 1ps
package sem_pkg;

   // Line store depth and the widths that follow from it
   localparam int MAX_WIDTH = 1024;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int FW_W      = 11;                        // frame_width register
   localparam int FH_W      = 13;                        // frame_height register
   localparam int EFFW_W    = (COL_W + 1 > FW_W) ? COL_W + 1 : FW_W;
   localparam int ROW_W     = FH_W + 1;                  // row counter runs past the last row
   localparam int CSR_DATA_W = FH_W;

   // Pixel layout: red in the low byte, then green, then blue
   localparam int CH_W   = 8;
   localparam int NUM_CH = 3;
   localparam int PIX_W  = CH_W * NUM_CH;

   // Gradient and root arithmetic
   localparam int GRAD_W     = 10;                       // |Gx|, |Gy| <= 1020
   localparam int SUM_W      = 2 * GRAD_W + 1;
   localparam int ROOT_W     = 16;                       // radicand below the clamp
   localparam int ROOT_STEPS = ROOT_W / 2;
   localparam int STEP_W     = $clog2(ROOT_STEPS);
   localparam logic [SUM_W-1:0] SUM_CLAMP = SUM_W'(65280);   // 255*255 + 255
   localparam logic [CH_W-1:0]  MAG_MAX   = CH_W'(255);

   // Register reset values
   localparam logic [FW_W-1:0] WIDTH_RESET  = FW_W'(640);
   localparam logic [FH_W-1:0] HEIGHT_RESET = FH_W'(480);

   // Register indexes
   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   // Request kinds
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef logic [PIX_W-1:0] pixel_type;

   // One classified request, handed from front to back
   typedef struct packed {
      pixel_type        pix;
      logic [COL_W-1:0] addr;
      logic             emit;
      logic             last;
      logic             edge_top;
      logic             edge_bot;
      logic             edge_lft;
      logic             edge_rgt;
   } q_entry_type;

endpackage

// File: rtl/sem_front.sv
// Front end: configuration registers, frame position counters and request classification.
// Depends on sem_pkg.
`timescale 1ns / 1ps
module sem_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [23:0]                      req_tdata,   // red, green, blue
   input  logic                             req_tuser,   // operation
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic                             csr_index,
   input  logic [sem_pkg::CSR_DATA_W-1:0]   csr_data,
   input  logic                             q_full,
   output logic                             q_push,
   output sem_pkg::q_entry_type             q_entry
);
   import sem_pkg::*;

   logic [FW_W-1:0]   width_ff, width_in;
   logic [FH_W-1:0]   height_ff, height_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [EFFW_W:0]   pend_ff, pend_in;

   logic [EFFW_W-1:0] w_eff, ocol;
   logic [FH_W-1:0]   h_eff;
   logic [ROW_W-1:0]  h_last, orow;
   logic [COL_W:0]    col_nx;
   logic [EFFW_W:0]   pend_nx;
   logic              flush_phase, accept, emit, last;

   assign csr_ready  = 1'b1;
   assign req_tready = !q_full;
   assign accept     = req_tvalid && !q_full;

   // Effective frame size
   always_comb begin
      if (width_ff == '0) begin
         w_eff = EFFW_W'(1);
      end else if (EFFW_W'(width_ff) > EFFW_W'(MAX_WIDTH)) begin
         w_eff = EFFW_W'(MAX_WIDTH);
      end else begin
         w_eff = EFFW_W'(width_ff);
      end
      h_eff  = (height_ff == '0) ? FH_W'(1) : height_ff;
      h_last = ROW_W'(h_eff) - ROW_W'(1);
   end

   // Classify the request and work out the position that leaves now
   always_comb begin
      flush_phase = row_ff >= ROW_W'(h_eff);
      col_nx      = (COL_W+1)'(col_ff) + (COL_W+1)'(1);
      pend_nx     = pend_ff + (EFFW_W+1)'(1);
      emit        = pend_nx > ((EFFW_W+1)'(w_eff) + (EFFW_W+1)'(1));
      if (col_ff == '0) begin
         orow = row_ff - ROW_W'(2);
         ocol = w_eff - EFFW_W'(1);
      end else begin
         orow = row_ff - ROW_W'(1);
         ocol = EFFW_W'(col_ff) - EFFW_W'(1);
      end
      last   = emit && (orow == h_last) && (ocol == w_eff - EFFW_W'(1));
      q_push = accept && !(req_tuser == OP_FLUSH && !flush_phase);

      q_entry.pix      = flush_phase ? '0 : req_tdata;
      q_entry.addr     = col_ff;
      q_entry.emit     = emit;
      q_entry.last     = last;
      q_entry.edge_top = (orow == '0);
      q_entry.edge_bot = (orow == h_last);
      q_entry.edge_lft = (ocol == '0);
      q_entry.edge_rgt = (ocol == w_eff - EFFW_W'(1));
   end

   // Next counter and register values
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      pend_in   = pend_ff;
      if (csr_valid) begin
         if (csr_index == REG_FRAME_WIDTH) begin
            width_in = csr_data[FW_W-1:0];
         end else begin
            height_in = csr_data[FH_W-1:0];
         end
         col_in  = '0;
         row_in  = '0;
         pend_in = '0;
      end else if (q_push) begin
         if (EFFW_W'(col_nx) >= w_eff) begin
            col_in = '0;
            row_in = row_ff + ROW_W'(1);
         end else begin
            col_in = col_nx[COL_W-1:0];
         end
         pend_in = emit ? pend_ff : pend_nx;
         if (last) begin
            col_in  = '0;
            row_in  = '0;
            pend_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
         pend_ff   <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         pend_ff   <= pend_in;
      end
   end

endmodule

// File: rtl/sem_queue.sv
// Short request queue between front end and back end.
// Depends on sem_pkg.
`timescale 1ns / 1ps
module sem_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  sem_pkg::q_entry_type  push_entry,
   output logic                  full,
   input  logic                  pop,
   output logic                  valid,
   output sem_pkg::q_entry_type  pop_entry
);
   import sem_pkg::*;

   q_entry_type       slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_W:0]   cnt_ff, cnt_in;

   assign full      = (cnt_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign valid     = (cnt_ff != '0);
   assign pop_entry = slot_ff[rd_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_in  = push ? wr_ff + QPTR_W'(1) : wr_ff;
      rd_in  = pop ? rd_ff + QPTR_W'(1) : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

endmodule

// File: rtl/sem_back.sv
// Back end: line store memory, 3x3 window, Sobel gradients, per-channel rounded root
// and the result register. Depends on sem_pkg.
`timescale 1ns / 1ps
module sem_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  sem_pkg::q_entry_type  q_entry,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata,   // red_edge, green_edge, blue_edge
   output logic                  rsp_tlast    // frame_last
);
   import sem_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_WIN  = 5'b00010,
      S_SQ   = 5'b00100,
      S_ROOT = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   q_entry_type        ent_ff;
   logic [2*PIX_W-1:0] store_mem [MAX_WIDTH];   // upper row high, middle row low
   logic [2*PIX_W-1:0] rd_ff;
   pixel_type          win_ff [3][3];
   pixel_type          win_in [3][3];
   logic [CH_W-1:0]    p [NUM_CH][3][3];
   logic [GRAD_W-1:0]  gx_ff [NUM_CH], gy_ff [NUM_CH];
   logic [GRAD_W-1:0]  gx_in [NUM_CH], gy_in [NUM_CH];
   logic [GRAD_W-1:0]  gpos [NUM_CH], gneg [NUM_CH], vpos [NUM_CH], vneg [NUM_CH];
   logic [SUM_W-1:0]   sum [NUM_CH];
   logic [ROOT_W-1:0]  x_ff [NUM_CH], r_ff [NUM_CH];
   logic [ROOT_W-1:0]  x_in [NUM_CH], r_in [NUM_CH];
   logic [ROOT_W:0]    trial [NUM_CH];
   logic               over_ff [NUM_CH];
   logic [ROOT_W-1:0]  bit_ff;
   logic [STEP_W-1:0]  step_ff;
   logic [CH_W-1:0]    mag [NUM_CH];
   logic               rsp_valid_ff, rsp_last_ff, load;
   logic [PIX_W-1:0]   rsp_data_ff;

   assign q_pop      = (state_ff == S_IDLE) && q_valid;
   assign load       = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Shift the window and take the new column from the stores and the request
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win_in[r][0] = win_ff[r][1];
         win_in[r][1] = win_ff[r][2];
      end
      win_in[0][2] = rd_ff[2*PIX_W-1:PIX_W];
      win_in[1][2] = rd_ff[PIX_W-1:0];
      win_in[2][2] = ent_ff.pix;
   end

   // Mask the frame border and form |Gx|, |Gy| per channel
   always_comb begin
      for (int k = 0; k < NUM_CH; k++) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               if ((r == 0 && ent_ff.edge_top) || (r == 2 && ent_ff.edge_bot) ||
                   (c == 0 && ent_ff.edge_lft) || (c == 2 && ent_ff.edge_rgt)) begin
                  p[k][r][c] = '0;
               end else begin
                  p[k][r][c] = win_in[r][c][k*CH_W +: CH_W];
               end
            end
         end
         gpos[k] = GRAD_W'(p[k][0][2]) + {1'b0, p[k][1][2], 1'b0} + GRAD_W'(p[k][2][2]);
         gneg[k] = GRAD_W'(p[k][0][0]) + {1'b0, p[k][1][0], 1'b0} + GRAD_W'(p[k][2][0]);
         vpos[k] = GRAD_W'(p[k][2][0]) + {1'b0, p[k][2][1], 1'b0} + GRAD_W'(p[k][2][2]);
         vneg[k] = GRAD_W'(p[k][0][0]) + {1'b0, p[k][0][1], 1'b0} + GRAD_W'(p[k][0][2]);
         gx_in[k] = (gpos[k] >= gneg[k]) ? gpos[k] - gneg[k] : gneg[k] - gpos[k];
         gy_in[k] = (vpos[k] >= vneg[k]) ? vpos[k] - vneg[k] : vneg[k] - vpos[k];
         sum[k]   = SUM_W'(gx_ff[k]) * SUM_W'(gx_ff[k]) +
                    SUM_W'(gy_ff[k]) * SUM_W'(gy_ff[k]);
      end
   end

   // One restoring root step per cycle in each lane, then round and clamp
   always_comb begin
      for (int k = 0; k < NUM_CH; k++) begin
         trial[k] = {1'b0, r_ff[k]} + {1'b0, bit_ff};
         if ({1'b0, x_ff[k]} >= trial[k]) begin
            x_in[k] = x_ff[k] - trial[k][ROOT_W-1:0];
            r_in[k] = (r_ff[k] >> 1) + bit_ff;
         end else begin
            x_in[k] = x_ff[k];
            r_in[k] = r_ff[k] >> 1;
         end
         if (over_ff[k]) begin
            mag[k] = MAG_MAX;
         end else if (x_ff[k] > r_ff[k]) begin
            mag[k] = r_ff[k][CH_W-1:0] + CH_W'(1);
         end else begin
            mag[k] = r_ff[k][CH_W-1:0];
         end
      end
   end

   // Sequence one request
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) state_in = S_WIN;
         end
         S_WIN: begin
            state_in = ent_ff.emit ? S_SQ : S_IDLE;
         end
         S_SQ: begin
            state_in = S_ROOT;
         end
         S_ROOT: begin
            if (step_ff == STEP_W'(ROOT_STEPS - 1)) state_in = S_DONE;
         end
         S_DONE: begin
            if (load) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state, window and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else begin
         state_ff <= state_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == S_WIN) begin
            win_ff <= win_in;
         end
      end
   end

   // Line store: read on pop, write back the shifted column
   always_ff @(posedge clock) begin
      if (q_pop) begin
         rd_ff <= store_mem[q_entry.addr];
      end
      if (state_ff == S_WIN) begin
         store_mem[ent_ff.addr] <= {rd_ff[PIX_W-1:0], ent_ff.pix};
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (q_pop) begin
         ent_ff <= q_entry;
      end
      case (state_ff)
         S_WIN: begin
            gx_ff <= gx_in;
            gy_ff <= gy_in;
         end
         S_SQ: begin
            for (int k = 0; k < NUM_CH; k++) begin
               x_ff[k]    <= sum[k][ROOT_W-1:0];
               r_ff[k]    <= '0;
               over_ff[k] <= sum[k] > SUM_CLAMP;
            end
            bit_ff  <= ROOT_W'(1) << (ROOT_W - 2);
            step_ff <= '0;
         end
         S_ROOT: begin
            x_ff    <= x_in;
            r_ff    <= r_in;
            bit_ff  <= bit_ff >> 2;
            step_ff <= step_ff + STEP_W'(1);
         end
         default: begin
         end
      endcase
      if (load) begin
         for (int k = 0; k < NUM_CH; k++) begin
            rsp_data_ff[k*CH_W +: CH_W] <= mag[k];
         end
         rsp_last_ff <= ent_ff.last;
      end
   end

endmodule

// File: rtl/sobel_edge_magnitude_rgb.sv
// Throughput: the front takes one request a cycle into a four-deep queue while it is
// not full; the back takes a new request only when idle. It spends a line store read
// and a window update on a request that gives no result, and read, window, squares,
// 8 root steps and result load on one that does.
// Reset (synchronous, active high) clears counters, queue, window and result valid
// and sets frame_width 640, frame_height 480; the line store has no reset.
`timescale 1ns / 1ps
module sobel_edge_magnitude_rgb (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [23:0]                      req_tdata,   // red_in, green_in, blue_in
   input  logic                             req_tuser,   // operation
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [23:0]                      rsp_tdata,   // red_edge, green_edge, blue_edge
   output logic                             rsp_tlast,   // frame_last
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic                             csr_index,
   input  logic [sem_pkg::CSR_DATA_W-1:0]   csr_data
);
   import sem_pkg::*;

   q_entry_type push_entry, pop_entry;
   logic        q_full, q_push, q_valid, q_pop;

   sem_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (push_entry)
   );

   sem_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .valid      (q_valid),
      .pop_entry  (pop_entry)
   );

   sem_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_entry    (pop_entry),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: rtl/sem_checker.sv
// Port-level checks for the RGB Sobel edge magnitude block, bound to the top level.
// Depends on sem_pkg.
`timescale 1ns / 1ps
module sem_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [23:0]                      req_tdata,
   input logic                             req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [23:0]                      rsp_tdata,
   input logic                             rsp_tlast,
   input logic                             csr_valid,
   input logic                             csr_ready,
   input logic                             csr_index,
   input logic [sem_pkg::CSR_DATA_W-1:0]   csr_data
);
   import sem_pkg::*;

   // Drop any result after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // Queue is empty after reset, so a request can enter
   a_reset_ready: assert property (@(posedge clock) reset |=> req_tready)
      else $error("request not ready after reset");

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // Register writes are always taken
   a_csr_ready: assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("register port not ready");

endmodule

bind sobel_edge_magnitude_rgb sem_checker u_sem_checker (.*);
